// ===== src/sida_pkg.sv =====
`default_nettype none

package sida_pkg;

  // ASCII codes and the radix
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam int unsigned Radix     = 10;

  // Most digits a 32-bit magnitude can have
  localparam int unsigned MaxDigits = 10;

  // Reciprocal of ten: q = (m * RECIP_TEN) >> RecipShift is exact for any 32-bit m
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int unsigned RecipShift  = 35;

  typedef logic [3:0] digit_t;
  typedef logic [3:0] dcount_t;
  typedef logic [2:0] step_t;

  // Program addresses
  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_MUL   = 3'd1;
  localparam step_t STEP_DIV   = 3'd2;
  localparam step_t STEP_SIGN  = 3'd3;
  localparam step_t STEP_DIGIT = 3'd4;

  // Jump conditions
  typedef enum logic [1:0] {
    COND_NONE     = 2'd0,
    COND_IDLE     = 2'd1,
    COND_MORE_DIV = 2'd2,
    COND_MORE_DIG = 2'd3
  } cond_t;

  // Datapath controls of one step
  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic emit_sign;
    logic emit_digit;
  } ctrl_t;

  // Datapath flags seen by the sequencer
  typedef struct packed {
    logic more_div;
    logic more_dig;
  } stat_t;

  // One control word
  typedef struct packed {
    ctrl_t ctrl;
    cond_t cond;
    step_t jump;
    step_t next;
  } uword_t;

  // Control store
  function automatic uword_t rom_read(input step_t addr);
    uword_t w;
    w = '0;
    unique case (addr)
      STEP_IDLE: begin
        w.ctrl.load = 1'b1;
        w.cond      = COND_IDLE;
        w.jump      = STEP_IDLE;
        w.next      = STEP_MUL;
      end
      STEP_MUL: begin
        w.ctrl.mul  = 1'b1;
        w.cond      = COND_NONE;
        w.jump      = STEP_MUL;
        w.next      = STEP_DIV;
      end
      STEP_DIV: begin
        w.ctrl.div  = 1'b1;
        w.cond      = COND_MORE_DIV;
        w.jump      = STEP_MUL;
        w.next      = STEP_SIGN;
      end
      STEP_SIGN: begin
        w.ctrl.emit_sign = 1'b1;
        w.cond      = COND_NONE;
        w.jump      = STEP_SIGN;
        w.next      = STEP_DIGIT;
      end
      STEP_DIGIT: begin
        w.ctrl.emit_digit = 1'b1;
        w.cond      = COND_MORE_DIG;
        w.jump      = STEP_DIGIT;
        w.next      = STEP_IDLE;
      end
      default: begin
        w.cond      = COND_NONE;
        w.jump      = STEP_IDLE;
        w.next      = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== src/sida_dpath.sv =====
`default_nettype none

module sida_dpath import sida_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ctrl_t             ctrl,
  input  wire logic signed [31:0] value,
  output stat_t                  stat,
  output logic                   char_valid,
  output logic [7:0]             char_out,
  output logic                   last
);

  logic [31:0] mag;
  logic        neg;
  logic [63:0] prod;
  dcount_t     nd;
  digit_t      digits [MaxDigits];

  logic [28:0] quot;
  logic [31:0] quot_x10;
  logic [31:0] rem_full;
  dcount_t     rd_idx;

  // Quotient and remainder by ten from the registered product
  assign quot     = prod[63:RecipShift];
  assign quot_x10 = 32'({quot, 3'b000}) + 32'({quot, 1'b0});
  assign rem_full = mag - quot_x10;
  assign rd_idx   = nd - dcount_t'(1);

  assign stat.more_div = (quot != '0) && (nd < dcount_t'(MaxDigits - 1));
  assign stat.more_dig = (nd > dcount_t'(1));

  // Hold magnitude, sign, product and digit store
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      neg <= value[31];
      mag <= value[31] ? (~value + 32'd1) : value;
    end else if (ctrl.div) begin
      mag <= 32'(quot);
    end
    if (ctrl.mul) begin
      prod <= {32'b0, mag} * {32'b0, RECIP_TEN};
    end
    if (ctrl.div) begin
      digits[nd] <= rem_full[3:0];
    end
  end

  // Advance the digit count
  always_ff @(posedge clk) begin
    if (rst) begin
      nd <= '0;
    end else if (ctrl.load) begin
      nd <= '0;
    end else if (ctrl.div) begin
      nd <= nd + dcount_t'(1);
    end else if (ctrl.emit_digit) begin
      nd <= rd_idx;
    end
  end

  // Register the output character
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else begin
      char_valid <= (ctrl.emit_sign && neg) || ctrl.emit_digit;
    end
    if (ctrl.emit_sign) begin
      char_out <= CHAR_MINUS;
      last     <= 1'b0;
    end else if (ctrl.emit_digit) begin
      char_out <= CHAR_ZERO + 8'(digits[rd_idx]);
      last     <= (nd == dcount_t'(1));
    end
  end

endmodule

`default_nettype wire

// ===== src/signed_int_to_decimal_ascii.sv =====
`default_nettype none

// Signed 32-bit integer to decimal ASCII text.
// Command channel: value is taken at a rising edge where start is high and busy
// is low. busy stays high until the last character has been issued; that
// character is on the ports in the first cycle with busy low.
// Result channel: each character is on char_out for one cycle with char_valid
// high; last marks the final character. A negative number starts with '-',
// digits follow most significant first with no leading zeros, zero gives '0'.
// The receiver cannot stall; every character is taken in its cycle.
// Sequence for a number of 1 to 10 digits: for each digit the divide-by-ten
// loop does a registered reciprocal multiply step, then a remainder step; one
// sign step follows, then the digits are sent one per cycle. A new number is
// taken only in the idle step, once busy is low. The minus sign of a negative
// number is sent when the divide loop is done, and the digits follow it back
// to back.
// The control program is a five-word table stepped by a program counter.
// Reset idles the sequencer and clears the digit count and char_valid only.

module signed_int_to_decimal_ascii import sida_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] value,
  output logic                    char_valid,
  output logic [7:0]              char_out,
  output logic                    last
);

  step_t  step;
  step_t  step_next;
  uword_t uword;
  ctrl_t  ctrl;
  stat_t  stat;
  logic   take_jump;

  // Fetch the control word
  assign uword = rom_read(step);
  assign busy  = (step != STEP_IDLE);

  // Gate the load with the command strobe
  always_comb begin
    ctrl      = uword.ctrl;
    ctrl.load = uword.ctrl.load && start;
  end

  // Resolve the jump condition
  always_comb begin
    unique case (uword.cond)
      COND_NONE:     take_jump = 1'b0;
      COND_IDLE:     take_jump = !start;
      COND_MORE_DIV: take_jump = stat.more_div;
      COND_MORE_DIG: take_jump = stat.more_dig;
      default:       take_jump = 1'b0;
    endcase
    step_next = take_jump ? uword.jump : uword.next;
  end

  // Advance the program counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  sida_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .value      (value),
    .stat       (stat),
    .char_valid (char_valid),
    .char_out   (char_out),
    .last       (last)
  );

  // An accepted command always makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // The final character is followed by a quiet cycle
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (char_valid && last) |=> !char_valid)
    else $error("character right after last");

  // Only a minus sign or a decimal digit is sent
  a_char_code: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> (char_out == CHAR_MINUS) ||
                   ((char_out >= CHAR_ZERO) && (char_out <= CHAR_ZERO + 8'd9)))
    else $error("bad character code");

  // A minus sign is never the final character
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    (char_valid && (char_out == CHAR_MINUS)) |-> !last)
    else $error("sign marked last");

endmodule

`default_nettype wire
